FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_ON(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: src/gepr_pkg.sv
// ---------------------------------------------------------------------------
// gepr_pkg
// Types, constants and helpers for the generalised epipolar residual block.
// ---------------------------------------------------------------------------
package gepr_pkg;

    localparam int Q_W     = 16;   // Q4.12 operand
    localparam int ROW_W   = 3 * Q_W;
    localparam int NUM_CFG = 6;
    localparam int IDX_W   = 3;
    localparam int RES_W   = 32;   // Q20.12 result

    localparam int P_W   = 2 * Q_W;      // pair product
    localparam int SA_W  = P_W + 2;      // sum of three pair products
    localparam int SB_W  = P_W + 3;      // sum of six pair products
    localparam int T_W   = Q_W + SB_W + 1;
    localparam int SUM_W = T_W + 4;
    localparam int FRAC_DROP = 24;       // 2^-36 down to 2^-12

    localparam logic [IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ESS_ROW0 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ESS_ROW1 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ESS_ROW2 = 3'd5;

    localparam logic signed [Q_W-1:0] ONE_Q12 = 16'sd4096;

    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h1000_0000_0000;
    localparam logic [ROW_W-1:0] ESS_ROW_RST  = 48'h0;

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd8388608);
    localparam logic signed [SUM_W-1:0] OUT_MAX  = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] OUT_MIN  = SUM_W'(-64'sd2147483648);

    typedef struct packed {
        logic signed [Q_W-1:0] ref_dir_u;
        logic signed [Q_W-1:0] ref_dir_v;
        logic signed [Q_W-1:0] cur_dir_u;
        logic signed [Q_W-1:0] cur_dir_v;
        logic signed [Q_W-1:0] ref_moment_x;
        logic signed [Q_W-1:0] ref_moment_y;
        logic signed [Q_W-1:0] ref_moment_z;
        logic signed [Q_W-1:0] cur_moment_x;
        logic signed [Q_W-1:0] cur_moment_y;
        logic signed [Q_W-1:0] cur_moment_z;
    } in_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] err_first;
        logic signed [RES_W-1:0] err_second;
    } out_item_t;

    typedef logic signed [Q_W-1:0] q_vec_t [3];

    // Column 0 sits in the low bits of a packed row.
    function automatic logic signed [Q_W-1:0] row_entry(input logic [ROW_W-1:0] row,
                                                        input logic [1:0] col);
        return $signed(row[Q_W*col +: Q_W]);
    endfunction

endpackage

FILE: src/generalized_epipolar_residual_top.sv
// ---------------------------------------------------------------------------
// generalized_epipolar_residual_top
// Residual bc'R.ar + ac'R.br + ac'E.ar of one correspondence, Q20.12 out.
// ---------------------------------------------------------------------------
// One item is taken every cycle; busy never rises and cfg_ready is always
// high. done rises once the item has passed v1_reg to v4_reg and done_reg,
// and the result in res_reg is valid while done is high.
// The pipeline is pair products, row sums, the second multiplier rank, the
// final six-term sum and a rounding/saturation stage, each a register.
// The receiver cannot stall, so results are presented for one cycle only.
// The user must load matrices through the configuration channel while no item
// is in flight (unchecked by the block); after reset R is identity, E is zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module generalized_epipolar_residual_top
    import gepr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             done,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0] cfg_data
);

    logic [ROW_W-1:0] cfg_reg [NUM_CFG];

    logic accept;
    logic cfg_we;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Configuration registers; out-of-range indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= ROT_ROW0_RST;
            cfg_reg[1] <= ROT_ROW1_RST;
            cfg_reg[2] <= ROT_ROW2_RST;
            cfg_reg[3] <= ESS_ROW_RST;
            cfg_reg[4] <= ESS_ROW_RST;
            cfg_reg[5] <= ESS_ROW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_ROW0: cfg_reg[0] <= cfg_data;
                REG_ROT_ROW1: cfg_reg[1] <= cfg_data;
                REG_ROT_ROW2: cfg_reg[2] <= cfg_data;
                REG_ESS_ROW0: cfg_reg[3] <= cfg_data;
                REG_ESS_ROW1: cfg_reg[4] <= cfg_data;
                REG_ESS_ROW2: cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: pair products ----------------
    logic signed [P_W-1:0] rar_next [3][3];
    logic signed [P_W-1:0] rbr_next [3][3];
    logic signed [P_W-1:0] ear_next [3][3];
    logic signed [P_W-1:0] rar_reg  [3][3];
    logic signed [P_W-1:0] rbr_reg  [3][3];
    logic signed [P_W-1:0] ear_reg  [3][3];
    logic signed [Q_W-1:0] ac1_reg  [3];
    logic signed [Q_W-1:0] bc1_reg  [3];
    logic                  v1_reg;

    q_vec_t ar;
    q_vec_t br;
    q_vec_t ac;
    q_vec_t bc;

    always_comb
    begin
        ar[0] = item.ref_dir_u;
        ar[1] = item.ref_dir_v;
        ar[2] = ONE_Q12;
        ac[0] = item.cur_dir_u;
        ac[1] = item.cur_dir_v;
        ac[2] = ONE_Q12;
        br[0] = item.ref_moment_x;
        br[1] = item.ref_moment_y;
        br[2] = item.ref_moment_z;
        bc[0] = item.cur_moment_x;
        bc[1] = item.cur_moment_y;
        bc[2] = item.cur_moment_z;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rar_next[r][c] = P_W'(row_entry(cfg_reg[r], 2'(c))) * P_W'(ar[c]);
                rbr_next[r][c] = P_W'(row_entry(cfg_reg[r], 2'(c))) * P_W'(br[c]);
                ear_next[r][c] = P_W'(row_entry(cfg_reg[3 + r], 2'(c))) * P_W'(ar[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rar_reg[r][c] <= rar_next[r][c];
                rbr_reg[r][c] <= rbr_next[r][c];
                ear_reg[r][c] <= ear_next[r][c];
            end
            ac1_reg[r] <= ac[r];
            bc1_reg[r] <= bc[r];
        end
    end

    // ---------------- stage 2: row sums ----------------
    logic signed [SA_W-1:0] sa_next [3];
    logic signed [SB_W-1:0] sb_next [3];
    logic signed [SA_W-1:0] sa_reg  [3];
    logic signed [SB_W-1:0] sb_reg  [3];
    logic signed [Q_W-1:0]  ac2_reg [3];
    logic signed [Q_W-1:0]  bc2_reg [3];
    logic                   v2_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            // (R.ar)[r] and (R.br + E.ar)[r]
            sa_next[r] = SA_W'(rar_reg[r][0]) + SA_W'(rar_reg[r][1])
                       + SA_W'(rar_reg[r][2]);
            sb_next[r] = SB_W'(rbr_reg[r][0]) + SB_W'(rbr_reg[r][1])
                       + SB_W'(rbr_reg[r][2]) + SB_W'(ear_reg[r][0])
                       + SB_W'(ear_reg[r][1]) + SB_W'(ear_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            sa_reg[r]  <= sa_next[r];
            sb_reg[r]  <= sb_next[r];
            ac2_reg[r] <= ac1_reg[r];
            bc2_reg[r] <= bc1_reg[r];
        end
    end

    // ---------------- stage 3: second multiplier rank ----------------
    logic signed [T_W-1:0] tc_next [3];
    logic signed [T_W-1:0] ta_next [3];
    logic signed [T_W-1:0] tc_reg  [3];
    logic signed [T_W-1:0] ta_reg  [3];
    logic                  v3_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tc_next[r] = T_W'(bc2_reg[r]) * T_W'(sa_reg[r]);
            ta_next[r] = T_W'(ac2_reg[r]) * T_W'(sb_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            tc_reg[r] <= tc_next[r];
            ta_reg[r] <= ta_next[r];
        end
    end

    // ---------------- stage 4: exact sum at 2^-36 ----------------
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    v4_reg;

    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            sum_next = sum_next + SUM_W'(tc_reg[r]) + SUM_W'(ta_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // ---------------- stage 5: round to nearest, saturate ----------------
    logic signed [SUM_W-1:0] rnd;
    logic signed [RES_W-1:0] res_next;
    logic signed [RES_W-1:0] res_reg;
    logic                    done_reg;

    always_comb
    begin
        // floor((sum + half) / 2^24): ties go toward plus infinity
        rnd = (sum_reg + HALF_LSB) >>> FRAC_DROP;
        priority if (rnd > OUT_MAX)
            res_next = OUT_MAX[RES_W-1:0];
        else if (rnd < OUT_MIN)
            res_next = OUT_MIN[RES_W-1:0];
        else
            res_next = rnd[RES_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Valid bits ride alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    assign done              = done_reg;
    assign result.err_first  = res_reg;
    assign result.err_second = res_reg;

    // ---------------- checks ----------------
    `ASSERT_ON(a_done_latency, done |-> $past(accept, 5), "result without an item five cycles back")
    `ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "done strobe during reset")
    `ASSERT_ON(a_cfg_rot0, (cfg_we && cfg_index == REG_ROT_ROW0) |=> (cfg_reg[0] == $past(cfg_data)), "rotation row 0 write lost")
    `ASSERT_ON(a_cfg_ess2, (cfg_we && cfg_index == REG_ESS_ROW2) |=> (cfg_reg[5] == $past(cfg_data)), "essential row 2 write lost")

endmodule
